/* rtl/nvt_pkg.sv */
`timescale 1ns / 1ps

package nvt_pkg;

    localparam int NAME_W   = 64;
    localparam int VALUE_W  = 64;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 3;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_REPLACED = 3'd2,
        ST_ADDED    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [NAME_W-1:0]  name;
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } back_state_t;

endpackage

/* rtl/nvt_front.sv */
`timescale 1ns / 1ps

module nvt_front #(
    parameter int NAME_CHARS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  logic [nvt_pkg::NAME_W-1:0]  key_name,
    input  logic [nvt_pkg::VALUE_W-1:0] write_value,
    input  logic [nvt_pkg::TAG_W-1:0]   type_tag,
    output logic                        cmd_vld,
    output nvt_pkg::cmd_t               cmd,
    input  logic                        cmd_pop
);
    import nvt_pkg::*;

    logic              alive;
    logic [NAME_W-1:0] norm_name;
    logic              push_ok;
    logic              pop_ok;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    // keep bytes from the top down until the first zero byte or the length limit
    always_comb
    begin
        norm_name = '0;
        alive     = 1'b1;
        for (int p = 0; p < 8; p++)
        begin
            if (alive && (p < NAME_CHARS) && (key_name[63-8*p -: 8] != 8'h00))
            begin
                norm_name[63-8*p -: 8] = key_name[63-8*p -: 8];
            end
            else
            begin
                alive = 1'b0;
            end
        end
    end

    assign full    = (cnt_reg == 2'd2);
    assign push_ok = push && !full;
    assign cmd_vld = (cnt_reg != 2'd0);
    assign pop_ok  = cmd_pop && cmd_vld;
    assign cmd     = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_ok;
        rd_ptr_next = rd_ptr_reg ^ pop_ok;
        cnt_next    = cnt_reg + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= '{op: op_t'(opcode), name: norm_name,
                                   value: write_value, tag: type_tag};
        end
    end

endmodule

/* rtl/nvt_back.sv */
`timescale 1ns / 1ps

module nvt_back #(
    parameter int ENTRIES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_vld,
    input  nvt_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [nvt_pkg::STATUS_W-1:0] status,
    output logic [nvt_pkg::VALUE_W-1:0]  read_value,
    output logic [nvt_pkg::TAG_W-1:0]    read_type
);
    import nvt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [NAME_W-1:0]  name_mem  [ENTRIES];
    logic [VALUE_W-1:0] value_mem [ENTRIES];
    logic [TAG_W-1:0]   tag_mem   [ENTRIES];

    logic [NAME_W-1:0]  name_rd_reg;
    logic [VALUE_W-1:0] value_rd_reg;
    logic [TAG_W-1:0]   tag_rd_reg;

    logic          mem_we;
    logic          name_we;
    logic [IW-1:0] wr_addr;

    back_state_t   state_reg,     state_next;
    cmd_t          cmd_reg,       cmd_next;
    logic [CW-1:0] count_reg,     count_next;
    logic [IW-1:0] scan_addr_reg, scan_addr_next;
    logic          cmp_vld_reg,   cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg,   cmp_idx_next;
    logic          cmp_last_reg,  cmp_last_next;
    logic          hit_reg,       hit_next;
    logic [IW-1:0] hit_idx_reg,   hit_idx_next;

    logic [VALUE_W-1:0] hold_value_reg, hold_value_next;
    logic [TAG_W-1:0]   hold_tag_reg,   hold_tag_next;

    logic               out_vld_reg,    out_vld_next;
    status_t            out_status_reg, out_status_next;
    logic [VALUE_W-1:0] out_value_reg,  out_value_next;
    logic [TAG_W-1:0]   out_tag_reg,    out_tag_next;

    assign empty      = !out_vld_reg;
    assign status     = out_status_reg;
    assign read_value = out_value_reg;
    assign read_type  = out_tag_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_last_next   = cmp_last_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hold_value_next = hold_value_reg;
        hold_tag_next   = hold_tag_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_tag_next    = out_tag_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        name_we         = 1'b0;
        wr_addr         = hit_idx_reg;

        if (pop && out_vld_reg)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_vld)
                begin
                    cmd_pop        = 1'b1;
                    cmd_next       = cmd;
                    scan_addr_next = '0;
                    cmp_vld_next   = 1'b0;
                    hit_next       = 1'b0;
                    state_next     = (count_reg == '0) ? BK_FINISH : BK_SCAN;
                end
            end

            BK_SCAN:
            begin
                // one read issued and one entry compared per cycle
                scan_addr_next = scan_addr_reg + 1'b1;
                cmp_vld_next   = 1'b1;
                cmp_idx_next   = scan_addr_reg;
                cmp_last_next  = ((CW'(scan_addr_reg) + CW'(1)) == count_reg);
                if (cmp_vld_reg)
                begin
                    if (name_rd_reg == cmd_reg.name)
                    begin
                        hit_next        = 1'b1;
                        hit_idx_next    = cmp_idx_reg;
                        hold_value_next = value_rd_reg;
                        hold_tag_next   = tag_rd_reg;
                        state_next      = BK_FINISH;
                    end
                    else if (cmp_last_reg)
                    begin
                        hit_next   = 1'b0;
                        state_next = BK_FINISH;
                    end
                end
            end

            BK_FINISH:
            begin
                // hold until the result slot is free
                if (!out_vld_reg || pop)
                begin
                    out_vld_next   = 1'b1;
                    out_value_next = '0;
                    out_tag_next   = '0;
                    state_next     = BK_IDLE;
                    if (cmd_reg.op == OP_READ)
                    begin
                        if (hit_reg)
                        begin
                            out_status_next = ST_HIT;
                            out_value_next  = hold_value_reg;
                            out_tag_next    = hold_tag_reg;
                        end
                        else
                        begin
                            out_status_next = ST_MISS;
                        end
                    end
                    else if (hit_reg)
                    begin
                        out_status_next = ST_REPLACED;
                        mem_we          = 1'b1;
                    end
                    else if (count_reg < CW'(ENTRIES))
                    begin
                        out_status_next = ST_ADDED;
                        mem_we          = 1'b1;
                        name_we         = 1'b1;
                        wr_addr         = count_reg[IW-1:0];
                        count_next      = count_reg + CW'(1);
                    end
                    else
                    begin
                        out_status_next = ST_FULL;
                    end
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        scan_addr_reg  <= scan_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_last_reg   <= cmp_last_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hold_value_reg <= hold_value_next;
        hold_tag_reg   <= hold_tag_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_tag_reg    <= out_tag_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (name_we)
            begin
                name_mem[wr_addr] <= cmd_reg.name;
            end
            value_mem[wr_addr] <= cmd_reg.value;
            tag_mem[wr_addr]   <= cmd_reg.tag;
        end
        name_rd_reg  <= name_mem[scan_addr_reg];
        value_rd_reg <= value_mem[scan_addr_reg];
        tag_rd_reg   <= tag_mem[scan_addr_reg];
    end

endmodule

/* rtl/named_variable_table_unit.sv */
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// -------   ------------------  ------------------------------------------
// request   push / full         opcode, key_name, write_value, type_tag
// result    empty / pop         status, read_value, read_type
//
// A back-end pass scans the filled entries in order and stops at the first
// hit or after the last filled entry (at most ENTRIES); an empty table skips
// the scan. The name memory yields one entry per cycle to a single
// comparator. Reset clears the entry count but not the memories, which
// need no clearing pass. A two-deep request queue keeps accepting while a
// search runs, and a result slot holds one transaction while pop is low.

module named_variable_table_unit #(
    parameter int ENTRIES    = 64,
    parameter int NAME_CHARS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         opcode,
    input  logic [nvt_pkg::NAME_W-1:0]   key_name,
    input  logic [nvt_pkg::VALUE_W-1:0]  write_value,
    input  logic [nvt_pkg::TAG_W-1:0]    type_tag,
    output logic                         empty,
    input  logic                         pop,
    output logic [nvt_pkg::STATUS_W-1:0] status,
    output logic [nvt_pkg::VALUE_W-1:0]  read_value,
    output logic [nvt_pkg::TAG_W-1:0]    read_type
);
    import nvt_pkg::*;

    logic cmd_vld;
    cmd_t cmd;
    logic cmd_pop;

    nvt_front #(
        .NAME_CHARS (NAME_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .key_name    (key_name),
        .write_value (write_value),
        .type_tag    (type_tag),
        .cmd_vld     (cmd_vld),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    nvt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_vld    (cmd_vld),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .pop        (pop),
        .empty      (empty),
        .status     (status),
        .read_value (read_value),
        .read_type  (read_type)
    );

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_vld)
        else $error("request queue popped while empty");

    a_full_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cmd_vld)
        else $error("request queue full but shows nothing");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= ST_FULL))
        else $error("status code out of range");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != ST_HIT)) |-> ((read_value == '0) && (read_type == '0)))
        else $error("non-hit result carries data");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import nvt_pkg::*;

    localparam int ENTRIES        = 64;
    localparam int NAME_CHARS     = 8;
    localparam int POOL_SIZE      = 120;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int MAX_PRINTS     = 50;

    typedef struct {
        op_t               op;
        logic [NAME_W-1:0] name;
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]  tag;
        bit                drain;
    } queued_request_t;

    typedef struct {
        status_t            st;
        logic [VALUE_W-1:0] val;
        logic [TAG_W-1:0]   typ;
    } lookup_result_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic                opcode;
    logic [NAME_W-1:0]   key_name;
    logic [VALUE_W-1:0]  write_value;
    logic [TAG_W-1:0]    type_tag;
    logic                empty;
    logic                pop;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [TAG_W-1:0]    read_type;

    // Predicted table contents
    logic [NAME_W-1:0]  name_store [ENTRIES];
    logic [VALUE_W-1:0] value_store [ENTRIES];
    logic [TAG_W-1:0]   tag_store [ENTRIES];
    int                 fill_count;

    queued_request_t   pending[$];
    lookup_result_t    result_wait[$];
    logic [NAME_W-1:0] name_pool [POOL_SIZE];

    int mismatch_count;
    int idle_cycles;
    int gap_left;
    int stall_left;
    bit push_taken;
    bit calm;

    named_variable_table_unit #(
        .ENTRIES    (ENTRIES),
        .NAME_CHARS (NAME_CHARS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .key_name    (key_name),
        .write_value (write_value),
        .type_tag    (type_tag),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .read_value  (read_value),
        .read_type   (read_type)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] %s: got %h, want %h", $time, what, got, want);
    endtask

    // Keep bytes from the top until the first zero byte or NAME_CHARS, clear the rest
    function automatic logic [NAME_W-1:0] fold_name(logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] kept;
        logic [7:0]        ch;
        kept = '0;
        for (int pos = 0; pos < NAME_CHARS && pos < 8; pos++)
        begin
            ch = raw[63 - 8*pos -: 8];
            if (ch == 8'h00)
                break;
            kept[63 - 8*pos -: 8] = ch;
        end
        return kept;
    endfunction

    function automatic lookup_result_t apply_request(op_t op, logic [NAME_W-1:0] raw,
                                                     logic [VALUE_W-1:0] value,
                                                     logic [TAG_W-1:0] tag);
        lookup_result_t    res;
        logic [NAME_W-1:0] name;
        int                hit;
        name = fold_name(raw);
        hit = -1;
        res.val = '0;
        res.typ = '0;
        for (int k = 0; k < fill_count; k++)
        begin
            if (name_store[k] == name)
            begin
                hit = k;
                break;
            end
        end
        if (op == OP_READ)
        begin
            if (hit >= 0)
            begin
                res.st = ST_HIT;
                res.val = value_store[hit];
                res.typ = tag_store[hit];
            end
            else
                res.st = ST_MISS;
        end
        else if (hit >= 0)
        begin
            value_store[hit] = value;
            tag_store[hit] = tag;
            res.st = ST_REPLACED;
        end
        else if (fill_count < ENTRIES)
        begin
            name_store[fill_count] = name;
            value_store[fill_count] = value;
            tag_store[fill_count] = tag;
            fill_count++;
            res.st = ST_ADDED;
        end
        else
            res.st = ST_FULL;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Fill the bytes below the terminator with junk, half of the time, for names shorter than seven bytes
    function automatic logic [NAME_W-1:0] dress_name(logic [NAME_W-1:0] base);
        int                len;
        logic [NAME_W-1:0] junk;
        logic [NAME_W-1:0] keep_mask;
        len = 0;
        while (len < 8 && base[63 - 8*len -: 8] != 8'h00)
            len++;
        if (len >= 7 || $urandom_range(0, 1) == 0)
            return base;
        junk = {$urandom, $urandom};
        keep_mask = ~64'h0 << (64 - 8*(len + 1));
        return (base & keep_mask) | (junk & ~keep_mask);
    endfunction

    task automatic queue_request(input op_t op, input logic [NAME_W-1:0] name,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [TAG_W-1:0] tag, input bit drain);
        queued_request_t req;
        req.op = op;
        req.name = name;
        req.value = value;
        req.tag = tag;
        req.drain = drain;
        pending.push_back(req);
    endtask

    // Request driver
    always @(negedge clk)
    begin : request_driver
        queued_request_t req;
        if (rst_n)
        begin
            if (!push || push_taken)
            begin
                if (gap_left != 0)
                begin
                    push <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending.size() != 0 &&
                         (!pending[0].drain || result_wait.size() == 0))
                begin
                    req = pending.pop_front();
                    push <= 1'b1;
                    opcode <= req.op;
                    key_name <= req.name;
                    write_value <= req.value;
                    type_tag <= req.tag;
                    gap_left <= pick_gap();
                    if ($urandom_range(0, 199) == 0)
                        calm <= !calm;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Result sink
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                pop <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    // Monitor: check results, then predict for the accepted request
    always @(posedge clk)
    begin : monitor
        lookup_result_t want;
        if (!rst_n)
            push_taken <= 1'b0;
        else
        begin
            push_taken <= push && !full;
            if (pop && !empty)
            begin
                if (result_wait.size() == 0)
                    report_mismatch("result with nothing outstanding", 64'(status), 64'd0);
                else
                begin
                    want = result_wait.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 64'(status), 64'(want.st));
                    if (read_value !== want.val)
                        report_mismatch("read_value", read_value, want.val);
                    if (read_type !== want.typ)
                        report_mismatch("read_type", 64'(read_type), 64'(want.typ));
                end
            end
            if (push && !full)
                result_wait.push_back(apply_request(op_t'(opcode), key_name,
                                                    write_value, type_tag));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("named_variable_table_unit: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        logic [NAME_W-1:0] cand;
        bit                dup;
        int                len;
        int                span;
        int                r;
        op_t               op;
        logic [NAME_W-1:0] raw;

        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        opcode = OP_READ;
        key_name = '0;
        write_value = '0;
        type_tag = '0;
        fill_count = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        gap_left = 0;
        stall_left = 0;
        push_taken = 1'b0;
        calm = 1'b0;

        // Directed: empty table, empty name, junk after the terminator,
        // full-length names, a zero byte in the middle, replace
        queue_request(OP_READ,  64'h0, '0, '0, 1'b0);
        queue_request(OP_READ,  64'h4142_4344_0000_0000, '0, '0, 1'b0);
        queue_request(OP_WRITE, 64'h0, ~64'h0, 8'hFF, 1'b0);
        queue_request(OP_READ,  64'h00FF_FFFF_FFFF_FFFF, '0, '0, 1'b0);
        queue_request(OP_WRITE, 64'h4100_DEAD_BEEF_1234, 64'h1234_5678_9ABC_DEF0,
                      8'h3C, 1'b0);
        queue_request(OP_READ,  64'h4100_0000_0000_0000, '0, '0, 1'b0);
        queue_request(OP_WRITE, 64'h4100_FFFF_FFFF_FFFF, 64'h0, 8'h00, 1'b0);
        queue_request(OP_READ,  64'h4100_0102_0304_0506, '0, '0, 1'b0);
        queue_request(OP_WRITE, ~64'h0, 64'h5555_5555_5555_5555, 8'h55, 1'b0);
        queue_request(OP_READ,  ~64'h0, '0, '0, 1'b0);
        queue_request(OP_WRITE, 64'h0102_0304_0506_0708, 64'hAAAA_AAAA_AAAA_AAAA,
                      8'hAA, 1'b0);
        queue_request(OP_READ,  64'h0102_0304_0506_0708, '0, '0, 1'b0);
        queue_request(OP_READ,  64'h0102_0304_0506_0709, '0, '0, 1'b0);
        queue_request(OP_WRITE, 64'h4142_0043_4445_4647, 64'h8000_0000_0000_0001,
                      8'h80, 1'b0);
        queue_request(OP_READ,  64'h4142_0000_0000_00FF, '0, '0, 1'b0);
        queue_request(OP_READ,  64'h4142_4300_0000_0000, '0, '0, 1'b0);
        queue_request(OP_WRITE, 64'h0, 64'h0, 8'h01, 1'b0);
        queue_request(OP_READ,  64'h0011_2233_4455_6677, '0, '0, 1'b0);

        // Pool of distinct folded names of every length
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            do
            begin
                cand = '0;
                len = $urandom_range(0, 8);
                for (int b = 0; b < len; b++)
                    cand[63 - 8*b -: 8] = 8'($urandom_range(1, 255));
                dup = 1'b0;
                for (int q = 0; q < p; q++)
                    if (name_pool[q] == cand)
                        dup = 1'b1;
            end while (dup);
            name_pool[p] = cand;
        end

        // First stay below capacity, then widen the pool to fill the table
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            span = (i < 700) ? 40 : POOL_SIZE;
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                op = (i >= 700 && r < 4) ? OP_WRITE : OP_READ;
                raw = {$urandom, $urandom};
            end
            else
            begin
                op = ($urandom_range(0, 99) < ((i < 700) ? 50 : 35)) ? OP_WRITE : OP_READ;
                raw = dress_name(name_pool[$urandom_range(0, span - 1)]);
            end
            queue_request(op, raw, {$urandom, $urandom}, 8'($urandom), (i % 400 == 0));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || push)
            @(posedge clk);
        while (result_wait.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && result_wait.size() == 0)
            $display("named_variable_table_unit: match");
        else
            $display("named_variable_table_unit: mismatch");
        $finish;
    end

endmodule

/* files.f */
rtl/nvt_pkg.sv
rtl/nvt_front.sv
rtl/nvt_back.sv
rtl/named_variable_table_unit.sv
dv/tb_top.sv
